// File: rtl/core/rvlsu_pkg.sv
package rvlsu_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK               = 3'd0,
        ST_LOAD_MISALIGNED  = 3'd1,
        ST_STORE_MISALIGNED = 3'd2,
        ST_RANGE            = 3'd3,
        ST_BAD_WIDTH        = 3'd4
    } t_status;

    // funct3 width codes
    localparam logic [2:0] F3_B  = 3'd0;
    localparam logic [2:0] F3_H  = 3'd1;
    localparam logic [2:0] F3_W  = 3'd2;
    localparam logic [2:0] F3_BU = 3'd4;
    localparam logic [2:0] F3_HU = 3'd5;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // configuration register indexes
    localparam logic CFG_BIG_ENDIAN = 1'b0;
    localparam logic CFG_MEM_BYTES  = 1'b1;

    localparam int unsigned CFG_DATA_W = 13;
    localparam logic [CFG_DATA_W-1:0] MEM_BYTES_RESET = 13'd4096;

    // control from the access logic to the data memory
    typedef struct packed {
        logic       wr;
        logic       rd;
        logic [3:0] be;
    } t_mem_ctrl;

endpackage

// File: rtl/core/rvlsu_dmem.sv
module rvlsu_dmem #(
    parameter int unsigned WORDS = 1024,
    parameter int unsigned WAW   = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rvlsu_pkg::t_mem_ctrl  i_ctrl,
    input  logic [WAW-1:0]        i_addr,
    input  logic [31:0]           i_wdata,
    output logic [31:0]           o_rdata,
    output logic                  o_busy
);
    import rvlsu_pkg::*;

    logic           r_clearing;
    logic [WAW-1:0] r_clr_idx;

    // clearing sweep after reset, one word per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + WAW'(1);
            if (r_clr_idx == WAW'(WORDS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign o_busy = r_clearing;

    // four byte lanes, each its own memory
    for (genvar k = 0; k < 4; k++) begin : g_lane
        logic [7:0]     r_mem [WORDS];
        logic [7:0]     r_rd;
        logic           wr_en;
        logic [WAW-1:0] wr_addr;
        logic [7:0]     wr_data;

        assign wr_en   = r_clearing | (i_ctrl.wr & i_ctrl.be[k]);
        assign wr_addr = r_clearing ? r_clr_idx : i_addr;
        assign wr_data = r_clearing ? 8'h00 : i_wdata[8*k +: 8];

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_mem[wr_addr] <= wr_data;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctrl.rd) begin
                r_rd <= r_mem[i_addr];
            end
        end

        assign o_rdata[8*k +: 8] = r_rd;
    end

endmodule

// File: rtl/core/riscv_load_store_unit.sv
// RV32I load/store unit with a private byte-addressed data memory of MEM_BYTES
// bytes, kept as four byte-lane memories of (MEM_BYTES+3)/4 words. One access is
// taken per cycle while s_axis_tready is high (not in the clearing sweep, not
// while the output stalls). Checks and the memory access happen as an item
// enters the first stage, read data alignment and extension as it moves to the
// output register. After reset the memory is cleared one word per cycle, and no
// access is taken during that sweep; configuration writes are taken at any
// time. Status 0 ok, 1 load misaligned, 2 store misaligned, 3 out of range,
// 4 bad width; a failed access leaves memory, the held load value and the
// access counter unchanged, and a store or failed item returns the held value.
module riscv_load_store_unit #(
    parameter int unsigned MEM_BYTES = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [rvlsu_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // access stream in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [63:0]                       s_axis_tdata,  // address, store_value
    input  logic [3:0]                        s_axis_tuser,  // op, width_code
    // result stream out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [63:0]                       m_axis_tdata,  // load_data, access_count
    output logic [2:0]                        m_axis_tuser   // status
);
    import rvlsu_pkg::*;

    localparam int unsigned WORDS = (MEM_BYTES + 3) / 4;
    localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

    // configuration registers
    logic                  r_big_endian;
    logic [CFG_DATA_W-1:0] r_mem_bytes_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian     <= 1'b0;
            r_mem_bytes_used <= MEM_BYTES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BIG_ENDIAN: r_big_endian     <= i_cfg_wdata[0];
                CFG_MEM_BYTES:  r_mem_bytes_used <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input fields
    logic        in_op;
    logic [2:0]  in_w;
    logic [31:0] in_addr;
    logic [31:0] in_sval;

    assign in_op   = s_axis_tuser[0];
    assign in_w    = s_axis_tuser[3:1];
    assign in_addr = s_axis_tdata[31:0];
    assign in_sval = s_axis_tdata[63:32];

    // pipeline state
    logic        r_s1_valid;
    t_status     r_s1_status;
    logic        r_s1_load_ok;
    logic [2:0]  r_s1_w;
    logic [1:0]  r_s1_off;
    logic        r_s1_big;
    logic [31:0] r_s1_count;
    logic        r_out_valid;
    logic [31:0] r_out_data;
    t_status     r_out_status;
    logic [31:0] r_out_count;
    logic [31:0] r_held;
    logic [31:0] r_count;

    logic        mem_busy;
    logic [31:0] mem_rdata;
    t_mem_ctrl   mem_ctrl;
    logic [31:0] mem_wdata;

    logic        s1_move;
    logic        accept;

    assign s1_move       = r_s1_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~mem_busy & (~r_s1_valid | s1_move);
    assign accept        = s_axis_tvalid & s_axis_tready;

    // access checks: width code, then alignment, then bound
    t_status     chk_status;
    logic [1:0]  size;
    logic [1:0]  nm1;
    logic [32:0] last_byte;
    logic [32:0] bound;

    always_comb begin
        size      = in_w[1:0];
        nm1       = (size == 2'd0) ? 2'd0 : ((size == 2'd1) ? 2'd1 : 2'd3);
        last_byte = {1'b0, in_addr} + 33'(nm1);
        bound     = (33'(r_mem_bytes_used) > 33'(MEM_BYTES)) ? 33'(MEM_BYTES)
                                                              : 33'(r_mem_bytes_used);
        chk_status = ST_OK;
        if (in_op == OP_STORE) begin
            if (!(in_w inside {F3_B, F3_H, F3_W})) begin
                chk_status = ST_BAD_WIDTH;
            end
        end else begin
            if (!(in_w inside {F3_B, F3_H, F3_W, F3_BU, F3_HU})) begin
                chk_status = ST_BAD_WIDTH;
            end
        end
        if (chk_status == ST_OK) begin
            if ((size == 2'd1 && in_addr[0]) || (size == 2'd2 && in_addr[1:0] != 2'd0)) begin
                chk_status = (in_op == OP_STORE) ? ST_STORE_MISALIGNED
                                                 : ST_LOAD_MISALIGNED;
            end
        end
        if (chk_status == ST_OK) begin
            if (last_byte >= bound) begin
                chk_status = ST_RANGE;
            end
        end
    end

    // store lane steering and memory control
    always_comb begin
        logic [1:0] i;
        logic [1:0] sel;
        mem_wdata = '0;
        mem_ctrl  = '0;
        for (int k = 0; k < 4; k++) begin
            i   = 2'(k) - in_addr[1:0];
            sel = r_big_endian ? (nm1 - i) : i;
            mem_wdata[8*k +: 8] = in_sval[8*sel +: 8];
            mem_ctrl.be[k]      = (3'(k) >= {1'b0, in_addr[1:0]})
                                  && (3'(k) <= {1'b0, in_addr[1:0]} + {1'b0, nm1});
        end
        mem_ctrl.wr = accept & (chk_status == ST_OK) & (in_op == OP_STORE);
        mem_ctrl.rd = accept & (chk_status == ST_OK) & (in_op == OP_LOAD);
    end

    rvlsu_dmem #(
        .WORDS (WORDS),
        .WAW   (WAW)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mem_ctrl),
        .i_addr  (in_addr[WAW+1:2]),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    // first stage: status and counter of the accepted item
    logic [31:0] n_count;

    assign n_count = r_count + 32'(chk_status == ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_count    <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_count    <= n_count;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status  <= chk_status;
            r_s1_load_ok <= (chk_status == ST_OK) & (in_op == OP_LOAD);
            r_s1_w       <= in_w;
            r_s1_off     <= in_addr[1:0];
            r_s1_big     <= r_big_endian;
            r_s1_count   <= n_count;
        end
    end

    // load data gather and extension
    logic [31:0] ld_value;

    always_comb begin
        logic [1:0] s1_nm1;
        logic [1:0] lane;
        logic [1:0] pos;
        s1_nm1   = (r_s1_w[1:0] == 2'd0) ? 2'd0 : ((r_s1_w[1:0] == 2'd1) ? 2'd1 : 2'd3);
        ld_value = '0;
        for (int i = 0; i < 4; i++) begin
            lane = r_s1_off + 2'(i);
            pos  = r_s1_big ? (s1_nm1 - 2'(i)) : 2'(i);
            if (2'(i) <= s1_nm1) begin
                ld_value[8*pos +: 8] = mem_rdata[8*lane +: 8];
            end
        end
        if (!r_s1_w[2]) begin
            if (r_s1_w[1:0] == 2'd0 && ld_value[7]) begin
                ld_value[31:8] = '1;
            end else if (r_s1_w[1:0] == 2'd1 && ld_value[15]) begin
                ld_value[31:16] = '1;
            end
        end
    end

    // output register and held load value
    logic [31:0] n_held;

    assign n_held = r_s1_load_ok ? ld_value : r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_held      <= '0;
        end else begin
            if (s1_move) begin
                r_out_valid <= 1'b1;
                r_held      <= n_held;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data   <= n_held;
            r_out_status <= r_s1_status;
            r_out_count  <= r_s1_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_count, r_out_data};
    assign m_axis_tuser  = r_out_status;

endmodule

// File: tb/sv/tb_riscv_load_store_unit.sv
module tb_riscv_load_store_unit;
    import rvlsu_pkg::*;

    localparam int unsigned MEM_SIZE = 4096;
    localparam int unsigned RUN_LIMIT = 2_000_000;

    typedef struct packed {
        logic [31:0] load_data;
        t_status     status;
        logic [31:0] access_count;
    } t_lsu_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_index = CFG_BIG_ENDIAN;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata = '0;   // address, store_value
    logic [3:0]            s_axis_tuser = '0;   // op, width_code
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;        // load_data, access_count
    logic [2:0]            m_axis_tuser;        // status

    // shadow state of the unit
    logic [7:0]            byte_image [MEM_SIZE];
    logic [31:0]           held_value = '0;
    logic [31:0]           success_count = '0;
    logic                  cfg_big_endian = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_mem_bytes = MEM_BYTES_RESET;

    t_lsu_result           expected_results [$];
    t_lsu_result           observed;
    t_lsu_result           predicted;
    int unsigned           idle_pct = 0;
    int unsigned           mismatch_count = 0;
    int unsigned           accesses_sent = 0;
    int unsigned           results_checked = 0;
    int unsigned           good_accesses = 0;

    riscv_load_store_unit #(.MEM_BYTES(MEM_SIZE)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(RUN_LIMIT);
        $display("timeout: %0d results still outstanding", expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // memory is cleared at reset
    initial begin
        foreach (byte_image[i]) byte_image[i] = 8'h00;
    end

    // checks, width, alignment, bound, then the access itself
    function automatic t_lsu_result predict_access(logic op, logic [2:0] width,
                                                   logic [31:0] addr, logic [31:0] wdata);
        t_lsu_result           res;
        t_status               st;
        int unsigned           nbytes;
        int unsigned           sh;
        logic [32:0]           last_byte;
        logic [CFG_DATA_W-1:0] bound;
        logic [31:0]           value;
        st = ST_OK;
        nbytes = 1 << width[1:0];
        if (op == OP_STORE) begin
            if (!(width inside {F3_B, F3_H, F3_W})) st = ST_BAD_WIDTH;
        end else begin
            if (!(width inside {F3_B, F3_H, F3_W, F3_BU, F3_HU})) st = ST_BAD_WIDTH;
        end
        if (st == ST_OK && ((nbytes == 2 && addr[0]) || (nbytes == 4 && addr[1:0] != 2'b00)))
            st = (op == OP_STORE) ? ST_STORE_MISALIGNED : ST_LOAD_MISALIGNED;
        // bound check on the exact sum, register saturated to the memory size
        bound = (cfg_mem_bytes > MEM_SIZE) ? CFG_DATA_W'(MEM_SIZE) : cfg_mem_bytes;
        last_byte = {1'b0, addr} + 33'(nbytes - 1);
        if (st == ST_OK && last_byte >= 33'(bound)) st = ST_RANGE;
        if (st == ST_OK) begin
            if (op == OP_STORE) begin
                for (int i = 0; i < int'(nbytes); i++) begin
                    sh = cfg_big_endian ? 8 * (nbytes - 1 - i) : 8 * i;
                    byte_image[int'(addr) + i] = 8'(wdata >> sh);
                end
            end else begin
                value = '0;
                for (int i = 0; i < int'(nbytes); i++) begin
                    sh = cfg_big_endian ? 8 * (nbytes - 1 - i) : 8 * i;
                    value |= 32'(byte_image[int'(addr) + i]) << sh;
                end
                // sign extension unless an unsigned code
                if (!width[2] && nbytes == 1 && value[7]) value[31:8] = '1;
                if (!width[2] && nbytes == 2 && value[15]) value[31:16] = '1;
                held_value = value;
            end
            success_count = success_count + 1;
        end
        res.load_data = held_value;
        res.status = st;
        res.access_count = success_count;
        return res;
    endfunction

    function void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endfunction

    // result sink with random stalls
    initial begin
        forever begin
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            observed.load_data = m_axis_tdata[31:0];
            observed.status = t_status'(m_axis_tuser);
            observed.access_count = m_axis_tdata[63:32];
            results_checked++;
            if (expected_results.size() == 0) begin
                note_failure($sformatf("unexpected result: data %h status %0d count %0d",
                    observed.load_data, observed.status, observed.access_count));
            end else begin
                predicted = expected_results.pop_front();
                if (predicted.status == ST_OK) good_accesses++;
                if (observed.load_data !== predicted.load_data
                        || observed.status !== predicted.status
                        || observed.access_count !== predicted.access_count)
                    note_failure($sformatf(
                        "result %0d: expected data %h status %0d count %0d, got %h %0d %0d",
                        results_checked, predicted.load_data, predicted.status,
                        predicted.access_count, observed.load_data, observed.status,
                        observed.access_count));
            end
        end
    end

    // one access transfer, optionally after a source gap
    task automatic send_access(logic op, logic [2:0] width, logic [31:0] addr,
                               logic [31:0] wdata);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {wdata, addr};
        s_axis_tuser <= {width, op};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(predict_access(op, width, addr, wdata));
        accesses_sent++;
    endtask

    // stop the source and let every result come back
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic index, logic [CFG_DATA_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_BIG_ENDIAN) cfg_big_endian = value[0];
        else cfg_mem_bytes = value;
        @(posedge i_clk);
    endtask

    // mostly legal aligned accesses, clustered low and around the bound
    task automatic run_random(int count, int unsigned hot_span);
        logic        op;
        logic [2:0]  width;
        logic [31:0] addr;
        int unsigned nbytes;
        int unsigned bound;
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            op = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 85) begin
                if (op == OP_STORE) begin
                    case ($urandom_range(0, 2))
                        0: width = F3_B;
                        1: width = F3_H;
                        default: width = F3_W;
                    endcase
                end else begin
                    case ($urandom_range(0, 4))
                        0: width = F3_B;
                        1: width = F3_H;
                        2: width = F3_W;
                        3: width = F3_BU;
                        default: width = F3_HU;
                    endcase
                end
            end else begin
                width = 3'($urandom_range(0, 7));
            end
            nbytes = 1 << width[1:0];
            bound = (cfg_mem_bytes > MEM_SIZE) ? MEM_SIZE : cfg_mem_bytes;
            pick = $urandom_range(0, 99);
            if (pick < 55) addr = $urandom_range(0, hot_span - 1);
            else if (pick < 70) addr = bound - 8 + $urandom_range(0, 15);
            else if (pick < 80) addr = $urandom_range(0, MEM_SIZE - 1);
            else if (pick < 90) addr = $urandom;
            else addr = 32'hFFFF_FFF0 | $urandom_range(0, 15);
            if ($urandom_range(0, 99) < 88) addr &= ~32'(nbytes - 1);
            send_access(op, width, addr, $urandom);
        end
    endtask

    // field extremes, every width code, error precedence
    task automatic test_directed();
        idle_pct = 20;
        send_access(OP_STORE, F3_W, 32'h0, 32'h80FF_7F81);
        send_access(OP_LOAD, F3_B, 32'h0, 32'h0);
        send_access(OP_LOAD, F3_BU, 32'h0, 32'h0);
        send_access(OP_LOAD, F3_H, 32'h2, 32'h0);
        send_access(OP_LOAD, F3_HU, 32'h2, 32'h0);
        send_access(OP_LOAD, F3_W, 32'h0, 32'h0);
        // last byte of memory
        send_access(OP_STORE, F3_B, 32'hFFF, 32'hFFFF_FFFF);
        send_access(OP_LOAD, F3_B, 32'hFFF, 32'h0);
        send_access(OP_LOAD, F3_BU, 32'hFFF, 32'h0);
        send_access(OP_STORE, F3_W, 32'hFFC, 32'hFFFF_FFFF);
        send_access(OP_LOAD, F3_W, 32'hFFC, 32'h0);
        // out of range, including the top of the address space
        send_access(OP_STORE, F3_W, 32'h1000, 32'h1234_5678);
        send_access(OP_LOAD, F3_W, 32'hFFFF_FFFC, 32'h0);
        send_access(OP_LOAD, F3_H, 32'hFFFF_FFFE, 32'h0);
        send_access(OP_LOAD, F3_B, 32'hFFFF_FFFF, 32'h0);
        // misaligned, also where the address is out of range
        send_access(OP_LOAD, F3_H, 32'h1, 32'h0);
        send_access(OP_LOAD, F3_W, 32'h2, 32'h0);
        send_access(OP_STORE, F3_H, 32'h3, 32'hFFFF_FFFF);
        send_access(OP_STORE, F3_W, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // unknown width codes
        send_access(OP_LOAD, 3'd3, 32'h0, 32'h0);
        send_access(OP_LOAD, 3'd7, 32'h0, 32'h0);
        send_access(OP_STORE, F3_BU, 32'h0, 32'hFFFF_FFFF);
        send_access(OP_STORE, 3'd6, 32'h0, 32'hFFFF_FFFF);
    endtask

    // same data seen in both byte orders
    task automatic test_byte_order();
        drain_pipeline();
        cfg_write(CFG_BIG_ENDIAN, CFG_DATA_W'(1));
        send_access(OP_STORE, F3_W, 32'h10, 32'h1122_3344);
        send_access(OP_LOAD, F3_B, 32'h10, 32'h0);
        send_access(OP_LOAD, F3_HU, 32'h12, 32'h0);
        send_access(OP_STORE, F3_H, 32'h20, 32'hABCD_8001);
        send_access(OP_LOAD, F3_W, 32'h20, 32'h0);
        drain_pipeline();
        cfg_write(CFG_BIG_ENDIAN, CFG_DATA_W'(0));
        send_access(OP_LOAD, F3_W, 32'h10, 32'h0);
        send_access(OP_LOAD, F3_H, 32'h20, 32'h0);
    endtask

    // bound register from empty through saturation
    task automatic test_bound_settings();
        logic [CFG_DATA_W-1:0] bounds [10];
        bounds = '{13'd0, 13'd1, 13'd2, 13'd3, 13'd4, 13'd5, 13'd4095, 13'd4097,
                   13'd8191, 13'd4096};
        idle_pct = 30;
        foreach (bounds[k]) begin
            drain_pipeline();
            cfg_write(CFG_MEM_BYTES, bounds[k]);
            run_random(15, 16);
        end
    endtask

    // long random phases over byte order, bound and idling
    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            drain_pipeline();
            cfg_write(CFG_BIG_ENDIAN, CFG_DATA_W'($urandom_range(0, 1)));
            case (phase)
                0: cfg_write(CFG_MEM_BYTES, CFG_DATA_W'(4096));
                1: cfg_write(CFG_MEM_BYTES, CFG_DATA_W'(64));
                2: cfg_write(CFG_MEM_BYTES, CFG_DATA_W'($urandom_range(0, 8191)));
                3: cfg_write(CFG_MEM_BYTES, CFG_DATA_W'(8191));
                default: cfg_write(CFG_MEM_BYTES, CFG_DATA_W'($urandom_range(16, 4096)));
            endcase
            idle_pct = (phase % 3) * 25;
            run_random(150, (phase % 2 == 0) ? 64 : 1024);
        end
    endtask

    // back-to-back transfers, no stalls on either side
    task automatic test_full_rate();
        drain_pipeline();
        cfg_write(CFG_BIG_ENDIAN, CFG_DATA_W'(0));
        cfg_write(CFG_MEM_BYTES, CFG_DATA_W'(4096));
        idle_pct = 0;
        run_random(200, 128);
    endtask

    // test sequence
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_byte_order();
        test_bound_settings();
        test_random_traffic();
        test_full_rate();
        drain_pipeline();
        repeat (8) @(posedge i_clk);
        $display("%0d accesses sent, %0d results checked, %0d successful, %0d mismatches",
                 accesses_sent, results_checked, good_accesses, mismatch_count);
        $display("covered both byte orders, bounds 0 to 8191 and stalled and full-rate traffic");
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: riscv_load_store_unit.f
rtl/core/rvlsu_pkg.sv
rtl/core/rvlsu_dmem.sv
rtl/core/riscv_load_store_unit.sv
tb/sv/tb_riscv_load_store_unit.sv
